@@ rtl/sfla_pkg.sv @@
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types, constants and helpers of the segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 24;
	localparam int SIZE_CLASSES = 12;
	localparam int ALIGN_BYTES  = 8;
	localparam int MIN_HEAP     = 64;
	localparam int ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
	localparam int STORE_DEPTH  = HEAP_BYTES / ALIGN_BYTES;
	localparam int GRAN_W       = $clog2(STORE_DEPTH);
	localparam int HDR_GRAN     = HEADER_BYTES / ALIGN_BYTES;
	localparam int CLASS_W      = $clog2(SIZE_CLASSES);
	localparam int STEP_SLOTS   = 8;
	localparam int STEP_W       = $clog2(STEP_SLOTS);

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_FREE,
		OP_QUERY,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK,
		STAT_ZERO,
		STAT_NOSPACE,
		STAT_BADHDR,
		STAT_NOTALLOC
	} status_t;

	typedef struct packed {
		logic              valid;
		logic              is_free;
		logic              has_pm;
		logic              has_prev;
		logic              has_next;
		logic [GRAN_W-1:0] size;
		logic [GRAN_W-1:0] pm;
		logic [GRAN_W-1:0] prev;
		logic [GRAN_W-1:0] next;
	} hdr_t;

	localparam int HDR_W = $bits(hdr_t);

	typedef enum logic [1:0] {
		K_UNLINK,
		K_SUPPRESS,
		K_INSERT,
		K_CLEAR
	} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic [GRAN_W-1:0] addr;
		logic [GRAN_W-1:0] size;
		logic              ovr;
		logic [GRAN_W-1:0] pm;
	} step_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN_HEAD,
		S_SCAN_CHK,
		S_ADEC,
		S_LOC,
		S_NH,
		S_PH_RD,
		S_PH,
		S_FDEC,
		S_DISPATCH,
		S_CLR,
		S_X,
		S_P_WR,
		S_N_RD,
		S_N_WR,
		S_XW,
		S_H_WR,
		S_IX_WR,
		S_S_WR,
		S_DONE
	} state_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] request_bytes;
		logic [15:0] cell_address;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] data_address;
		logic [15:0] cell_bytes;
		logic [11:0] free_cell_count;
		logic [11:0] used_cell_count;
		logic [16:0] free_byte_count;
	} res_t;

	function automatic logic [CLASS_W-1:0] class_of(input logic [GRAN_W:0] g);
		logic [CLASS_W-1:0] k;
		k = '0;
		for (int i = 0; i < SIZE_CLASSES - 1; i++) begin
			if (g > ((GRAN_W+1)'(1) << i))
				k = k + CLASS_W'(1);
		end
		return k;
	endfunction

endpackage

@@ rtl/sfla_hdr_ram.sv @@
// ----------------------------------------------------------------------------
// sfla_hdr_ram
// Simple dual-port synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module sfla_hdr_ram #(
	parameter int WIDTH  = 57,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/sfla_engine.sv @@
// ----------------------------------------------------------------------------
// sfla_engine
// Header-memory sequencer: list search, relinking, merging and heap format.
// ----------------------------------------------------------------------------
module sfla_engine
	import sfla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	state_t state_q, state_d;

	logic              rd_en, wr_en;
	logic [GRAN_W-1:0] rd_addr, wr_addr;
	hdr_t              wr_data, rd_data;
	logic [HDR_W-1:0]  rd_raw;

	logic [16:0]       hb_q;
	logic [GRAN_W-1:0] clr_q;
	logic [GRAN_W-1:0] head_q [SIZE_CLASSES];
	logic [SIZE_CLASSES-1:0] ok_q;
	logic [11:0]       fcells_q, ucells_q;
	logic [16:0]       fbytes_q;

	op_t               op_q;
	logic [GRAN_W:0]   n_q;
	logic [GRAN_W-1:0] ca_q, cur_q, b_q, bsize_q, nx_q, nsize_q, psize_q;
	logic [CLASS_W-1:0] c_q, cls_q;
	logic              pass2_q, nf_q, pf_q;
	hdr_t              e_q, xr_q;
	step_t             steps_q [STEP_SLOTS];
	logic [STEP_W-1:0] idx_q, cnt_q;
	status_t           status_q;
	logic [15:0]       addr_q, bytes_q;

	step_t             stp;
	logic              step_done;
	logic [GRAN_W:0]   succ;
	logic              succ_ok;
	logic [CLASS_W-1:0] ci_ins, ci_unl;
	logic [GRAN_W:0]   nx_loc;
	logic [16:0]       cfg_v;
	logic [GRAN_W-1:0] ua_g;
	logic              loc_bad;
	logic [GRAN_W:0]   n_in;
	logic [GRAN_W-1:0] init_size;

	sfla_hdr_ram #(.WIDTH(HDR_W), .ADDR_W(GRAN_W)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	assign rd_data = hdr_t'(rd_raw);
	assign stp     = steps_q[idx_q];
	assign ci_ins  = class_of({1'b0, stp.size});
	assign ci_unl  = class_of({1'b0, rd_data.size});
	assign nx_loc  = (GRAN_W+1)'(ca_q) + (GRAN_W+1)'(HDR_GRAN) + (GRAN_W+1)'(rd_data.size);
	assign ua_g    = GRAN_W'(req.cell_address[15:ALIGN_SHIFT] - 13'(HDR_GRAN));
	assign loc_bad = (req.cell_address < 16'(HEADER_BYTES))
		|| (req.cell_address[ALIGN_SHIFT-1:0] != '0)
		|| ({1'b0, req.cell_address} > hb_q);
	assign n_in    = (GRAN_W+1)'(({1'b0, req.request_bytes} + 17'(ALIGN_BYTES - 1))
		>> ALIGN_SHIFT);
	assign init_size = GRAN_W'((hb_q - 17'(HEADER_BYTES)) >> ALIGN_SHIFT);

	always_comb begin
		if (stp.kind == K_INSERT)
			succ = (GRAN_W+1)'(stp.addr) + (GRAN_W+1)'(HDR_GRAN) + (GRAN_W+1)'(stp.size);
		else
			succ = (GRAN_W+1)'(stp.addr) + (GRAN_W+1)'(HDR_GRAN) + (GRAN_W+1)'(xr_q.size);
		succ_ok = {succ, 3'b000} < 17'(hb_q);
	end

	always_comb begin
		cfg_v = cfg_data;
		if (cfg_v < 17'(MIN_HEAP))
			cfg_v = 17'(MIN_HEAP);
		else if (cfg_v > 17'(HEAP_BYTES))
			cfg_v = 17'(HEAP_BYTES);
		cfg_v[ALIGN_SHIFT-1:0] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_CLEAR;
		else if (cfg_we)
			state_q <= S_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		step_done = 1'b0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				if (clr_q == '0) begin
					wr_data.valid   = 1'b1;
					wr_data.is_free = 1'b1;
					wr_data.size    = init_size;
				end
				if (clr_q == '1)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					case (req.op)
						OP_ALLOC: state_d = (req.request_bytes == '0) ? S_DONE : S_SCAN_HEAD;
						OP_FREE, OP_QUERY: begin
							if (loc_bad)
								state_d = S_DONE;
							else begin
								rd_en   = 1'b1;
								rd_addr = ua_g;
								state_d = S_LOC;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN_HEAD: begin
				if (ok_q[cls_q]) begin
					rd_en   = 1'b1;
					rd_addr = head_q[cls_q];
					state_d = S_SCAN_CHK;
				end else if (pass2_q)
					state_d = S_DONE;
			end
			S_SCAN_CHK: begin
				if ({1'b0, rd_data.size} >= n_q)
					state_d = S_ADEC;
				else if (rd_data.has_next) begin
					rd_en   = 1'b1;
					rd_addr = rd_data.next;
				end else if (pass2_q)
					state_d = S_DONE;
				else
					state_d = S_SCAN_HEAD;
			end
			S_ADEC: state_d = S_DISPATCH;
			S_LOC: begin
				if (!rd_data.valid || rd_data.is_free || op_q == OP_QUERY)
					state_d = S_DONE;
				else if ({nx_loc, 3'b000} < 17'(hb_q)) begin
					rd_en   = 1'b1;
					rd_addr = nx_loc[GRAN_W-1:0];
					state_d = S_NH;
				end else
					state_d = S_PH_RD;
			end
			S_NH: state_d = S_PH_RD;
			S_PH_RD: begin
				if (e_q.has_pm) begin
					rd_en   = 1'b1;
					rd_addr = e_q.pm;
					state_d = S_PH;
				end else
					state_d = S_FDEC;
			end
			S_PH: state_d = S_FDEC;
			S_FDEC: state_d = S_DISPATCH;
			S_DISPATCH: begin
				if (idx_q == cnt_q)
					state_d = S_DONE;
				else if (stp.kind == K_CLEAR)
					state_d = S_CLR;
				else begin
					rd_en   = 1'b1;
					rd_addr = stp.addr;
					state_d = S_X;
				end
			end
			S_CLR: begin
				wr_en     = 1'b1;
				wr_addr   = stp.addr;
				step_done = 1'b1;
				state_d   = S_DISPATCH;
			end
			S_X: begin
				if (stp.kind == K_INSERT) begin
					if (ok_q[ci_ins]) begin
						rd_en   = 1'b1;
						rd_addr = head_q[ci_ins];
						state_d = S_H_WR;
					end else
						state_d = S_IX_WR;
				end else if (rd_data.has_prev) begin
					rd_en   = 1'b1;
					rd_addr = rd_data.prev;
					state_d = S_P_WR;
				end else
					state_d = S_N_RD;
			end
			S_P_WR: begin
				wr_en            = 1'b1;
				wr_addr          = xr_q.prev;
				wr_data          = rd_data;
				wr_data.next     = xr_q.next;
				wr_data.has_next = xr_q.has_next;
				state_d          = S_N_RD;
			end
			S_N_RD: begin
				if (xr_q.has_next) begin
					rd_en   = 1'b1;
					rd_addr = xr_q.next;
					state_d = S_N_WR;
				end else
					state_d = S_XW;
			end
			S_N_WR: begin
				wr_en            = 1'b1;
				wr_addr          = xr_q.next;
				wr_data          = rd_data;
				wr_data.prev     = xr_q.prev;
				wr_data.has_prev = xr_q.has_prev;
				state_d          = S_XW;
			end
			S_XW: begin
				wr_en           = 1'b1;
				wr_addr         = stp.addr;
				wr_data         = xr_q;
				wr_data.is_free = 1'b0;
				if (stp.kind == K_UNLINK && stp.ovr)
					wr_data.size = stp.size;
				if (stp.kind == K_SUPPRESS && succ_ok) begin
					rd_en   = 1'b1;
					rd_addr = succ[GRAN_W-1:0];
					state_d = S_S_WR;
				end else begin
					step_done = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_H_WR: begin
				wr_en            = 1'b1;
				wr_addr          = head_q[ci_ins];
				wr_data          = rd_data;
				wr_data.prev     = stp.addr;
				wr_data.has_prev = 1'b1;
				state_d          = S_IX_WR;
			end
			S_IX_WR: begin
				wr_en            = 1'b1;
				wr_addr          = stp.addr;
				wr_data.valid    = 1'b1;
				wr_data.is_free  = 1'b1;
				wr_data.has_pm   = stp.ovr ? 1'b1 : xr_q.has_pm;
				wr_data.pm       = stp.ovr ? stp.pm : xr_q.pm;
				wr_data.size     = stp.size;
				wr_data.next     = head_q[ci_ins];
				wr_data.has_next = ok_q[ci_ins];
				if (succ_ok) begin
					rd_en   = 1'b1;
					rd_addr = succ[GRAN_W-1:0];
					state_d = S_S_WR;
				end else begin
					step_done = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_S_WR: begin
				wr_en     = 1'b1;
				wr_addr   = succ[GRAN_W-1:0];
				wr_data   = rd_data;
				if (stp.kind == K_INSERT) begin
					wr_data.pm     = stp.addr;
					wr_data.has_pm = 1'b1;
				end else begin
					wr_data.pm     = xr_q.pm;
					wr_data.has_pm = xr_q.has_pm;
				end
				step_done = 1'b1;
				state_d   = S_DISPATCH;
			end
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_q     <= 17'(HEAP_BYTES);
			clr_q    <= '0;
			for (int i = 0; i < SIZE_CLASSES; i++)
				head_q[i] <= '0;
			ok_q     <= SIZE_CLASSES'(1) << class_of(
				(GRAN_W+1)'((HEAP_BYTES - HEADER_BYTES) / ALIGN_BYTES));
			fcells_q <= 12'd1;
			ucells_q <= '0;
			fbytes_q <= 17'(HEAP_BYTES - HEADER_BYTES);
			idx_q    <= '0;
		end else if (cfg_we) begin
			hb_q     <= cfg_v;
			clr_q    <= '0;
			for (int i = 0; i < SIZE_CLASSES; i++)
				head_q[i] <= '0;
			ok_q     <= SIZE_CLASSES'(1) << class_of(
				(GRAN_W+1)'((cfg_v - 17'(HEADER_BYTES)) >> ALIGN_SHIFT));
			fcells_q <= 12'd1;
			ucells_q <= '0;
			fbytes_q <= cfg_v - 17'(HEADER_BYTES);
			idx_q    <= '0;
		end else begin
			if (state_q == S_CLEAR)
				clr_q <= clr_q + GRAN_W'(1);
			if (state_q == S_ADEC || state_q == S_FDEC)
				idx_q <= '0;
			else if (step_done)
				idx_q <= idx_q + STEP_W'(1);
			if (state_q == S_X && stp.kind != K_INSERT && !rd_data.has_prev) begin
				head_q[ci_unl] <= rd_data.next;
				ok_q[ci_unl]   <= rd_data.has_next;
			end
			if (state_q == S_IX_WR) begin
				head_q[ci_ins] <= stp.addr;
				ok_q[ci_ins]   <= 1'b1;
				fcells_q       <= fcells_q + 12'd1;
			end
			if (state_q == S_XW)
				fcells_q <= fcells_q - 12'd1;
			if (state_q == S_ADEC) begin
				ucells_q <= ucells_q + 12'd1;
				if (bsize_q - n_q[GRAN_W-1:0] <= GRAN_W'(HDR_GRAN))
					fbytes_q <= fbytes_q - {1'b0, bsize_q, 3'b000};
				else
					fbytes_q <= fbytes_q - {n_q + (GRAN_W+1)'(HDR_GRAN), 3'b000};
			end
			if (state_q == S_FDEC) begin
				ucells_q <= ucells_q - 12'd1;
				if (pf_q && nf_q)
					fbytes_q <= fbytes_q + {(GRAN_W+1)'(e_q.size) + (GRAN_W+1)'(2*HDR_GRAN),
						3'b000};
				else if (pf_q || nf_q)
					fbytes_q <= fbytes_q + {(GRAN_W+1)'(e_q.size) + (GRAN_W+1)'(HDR_GRAN),
						3'b000};
				else
					fbytes_q <= fbytes_q + {1'b0, e_q.size, 3'b000};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= req.op;
				n_q      <= n_in;
				c_q      <= class_of(n_in);
				cls_q    <= (class_of(n_in) == CLASS_W'(SIZE_CLASSES - 1)) ?
					class_of(n_in) : class_of(n_in) + CLASS_W'(1);
				pass2_q  <= class_of(n_in) == CLASS_W'(SIZE_CLASSES - 1);
				ca_q     <= ua_g;
				status_q <= STAT_OK;
				addr_q   <= '0;
				bytes_q  <= '0;
				if (req.op == OP_ALLOC && req.request_bytes == '0)
					status_q <= STAT_ZERO;
				if ((req.op == OP_FREE || req.op == OP_QUERY) && loc_bad)
					status_q <= STAT_BADHDR;
			end
			S_SCAN_HEAD: begin
				if (ok_q[cls_q])
					cur_q <= head_q[cls_q];
				else if (pass2_q)
					status_q <= STAT_NOSPACE;
				else if (cls_q == CLASS_W'(SIZE_CLASSES - 1)) begin
					cls_q   <= c_q;
					pass2_q <= 1'b1;
				end else
					cls_q <= cls_q + CLASS_W'(1);
			end
			S_SCAN_CHK: begin
				if ({1'b0, rd_data.size} >= n_q) begin
					b_q     <= cur_q;
					bsize_q <= rd_data.size;
				end else if (rd_data.has_next)
					cur_q <= rd_data.next;
				else if (pass2_q)
					status_q <= STAT_NOSPACE;
				else if (cls_q == CLASS_W'(SIZE_CLASSES - 1)) begin
					cls_q   <= c_q;
					pass2_q <= 1'b1;
				end else
					cls_q <= cls_q + CLASS_W'(1);
			end
			S_ADEC: begin
				addr_q <= {b_q + GRAN_W'(HDR_GRAN), 3'b000};
				steps_q[0].ovr <= 1'b0;
				if (bsize_q - n_q[GRAN_W-1:0] <= GRAN_W'(HDR_GRAN)) begin
					bytes_q         <= {bsize_q, 3'b000};
					cnt_q           <= STEP_W'(1);
					steps_q[0].kind <= K_UNLINK;
					steps_q[0].addr <= b_q;
				end else begin
					bytes_q         <= {n_q[GRAN_W-1:0], 3'b000};
					cnt_q           <= STEP_W'(2);
					steps_q[0].kind <= K_INSERT;
					steps_q[0].addr <= b_q + GRAN_W'(HDR_GRAN) + n_q[GRAN_W-1:0];
					steps_q[0].size <= bsize_q - n_q[GRAN_W-1:0] - GRAN_W'(HDR_GRAN);
					steps_q[0].ovr  <= 1'b1;
					steps_q[0].pm   <= b_q;
					steps_q[1].kind <= K_UNLINK;
					steps_q[1].addr <= b_q;
					steps_q[1].size <= n_q[GRAN_W-1:0];
					steps_q[1].ovr  <= 1'b1;
				end
			end
			S_LOC: begin
				e_q  <= rd_data;
				nx_q <= nx_loc[GRAN_W-1:0];
				nf_q <= 1'b0;
				pf_q <= 1'b0;
				if (!rd_data.valid)
					status_q <= STAT_BADHDR;
				else if (rd_data.is_free)
					status_q <= STAT_NOTALLOC;
				else
					bytes_q <= {rd_data.size, 3'b000};
			end
			S_NH: begin
				nf_q    <= rd_data.is_free;
				nsize_q <= rd_data.size;
			end
			S_PH: begin
				pf_q    <= rd_data.is_free;
				psize_q <= rd_data.size;
			end
			S_FDEC: begin
				for (int i = 0; i < 5; i++)
					steps_q[i].ovr <= 1'b0;
				if (pf_q && nf_q) begin
					cnt_q           <= STEP_W'(5);
					steps_q[0].kind <= K_SUPPRESS;
					steps_q[0].addr <= e_q.pm;
					steps_q[1].kind <= K_SUPPRESS;
					steps_q[1].addr <= nx_q;
					steps_q[2].kind <= K_INSERT;
					steps_q[2].addr <= e_q.pm;
					steps_q[2].size <= psize_q + e_q.size + nsize_q + GRAN_W'(2*HDR_GRAN);
					steps_q[3].kind <= K_CLEAR;
					steps_q[3].addr <= ca_q;
					steps_q[4].kind <= K_CLEAR;
					steps_q[4].addr <= nx_q;
				end else if (pf_q) begin
					cnt_q           <= STEP_W'(3);
					steps_q[0].kind <= K_SUPPRESS;
					steps_q[0].addr <= e_q.pm;
					steps_q[1].kind <= K_INSERT;
					steps_q[1].addr <= e_q.pm;
					steps_q[1].size <= psize_q + e_q.size + GRAN_W'(HDR_GRAN);
					steps_q[2].kind <= K_CLEAR;
					steps_q[2].addr <= ca_q;
				end else if (nf_q) begin
					cnt_q           <= STEP_W'(3);
					steps_q[0].kind <= K_SUPPRESS;
					steps_q[0].addr <= nx_q;
					steps_q[1].kind <= K_INSERT;
					steps_q[1].addr <= ca_q;
					steps_q[1].size <= e_q.size + nsize_q + GRAN_W'(HDR_GRAN);
					steps_q[2].kind <= K_CLEAR;
					steps_q[2].addr <= nx_q;
				end else begin
					cnt_q           <= STEP_W'(1);
					steps_q[0].kind <= K_INSERT;
					steps_q[0].addr <= ca_q;
					steps_q[0].size <= e_q.size;
				end
			end
			S_X: xr_q <= rd_data;
			default: ;
		endcase
	end

	assign res.status          = status_q;
	assign res.data_address    = addr_q;
	assign res.cell_bytes      = bytes_q;
	assign res.free_cell_count = fcells_q;
	assign res.used_cell_count = ucells_q;
	assign res.free_byte_count = fbytes_q;

endmodule

@@ rtl/segregated_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// segregated_free_list_allocator
// Heap allocator with power-of-two size-class free lists and coalescing.
// ----------------------------------------------------------------------------
// An allocate scans the free lists of the classes above its own, then its own
// class, cell by cell until a cell fits; a free merges the cell with any free
// neighbour on either side. The next transaction can be accepted in the cycle
// in which m_axis_tvalid rises; a result waits in an output register meanwhile.
// Reset and every cfg_we write start a clearing pass over the header memory,
// during which no transaction is accepted.
module segregated_free_list_allocator
	import sfla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // request_bytes, cell_address
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,  // data_address, cell_bytes, free_cell_count,
	                                   // used_cell_count, free_byte_count
	output logic [2:0]  m_axis_tuser   // status
);

	req_t req;
	res_t res;
	res_t out_q;
	logic res_valid, res_ready, out_valid_q;

	assign req.op            = op_t'(s_axis_tuser);
	assign req.request_bytes = s_axis_tdata[15:0];
	assign req.cell_address  = s_axis_tdata[31:16];

	sfla_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_ready)
			out_valid_q <= res_valid;
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tdata  = {7'd0, out_q.free_byte_count, out_q.used_cell_count,
		out_q.free_cell_count, out_q.cell_bytes, out_q.data_address};

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second transaction accepted while one is in progress");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != STAT_OK |-> m_axis_tdata[15:0] == '0)
		else $error("failed result carries an address");

	a_cell_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> 13'(m_axis_tdata[43:32]) + 13'(m_axis_tdata[55:44]) <= 13'd2730)
		else $error("cell counts exceed heap capacity");

	a_free_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[72:56] <= 17'(HEAP_BYTES))
		else $error("free byte count exceeds heap");

endmodule

@@ verif/sfla_checker.sv @@
// ----------------------------------------------------------------------------
// sfla_checker
// Watches the request, response and configuration ports of the allocator,
// keeps its own copy of the heap headers and free lists, predicts every
// response and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sfla_checker
	import sfla_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [16:0] cfg_data,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [79:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	bit          c_valid [STORE_DEPTH];
	bit          c_free  [STORE_DEPTH];
	bit          c_haspm [STORE_DEPTH];
	bit          c_hasprv[STORE_DEPTH];
	bit          c_hasnxt[STORE_DEPTH];
	int unsigned c_size  [STORE_DEPTH];
	int unsigned c_pm    [STORE_DEPTH];
	int unsigned c_prv   [STORE_DEPTH];
	int unsigned c_nxt   [STORE_DEPTH];
	int unsigned list_head[SIZE_CLASSES];
	bit          list_ok  [SIZE_CLASSES];
	int unsigned top_addr, free_byte_total, free_cell_total, used_cell_total, heap_size;
	res_t        expected_responses[$];

	function automatic int unsigned gi(int unsigned a);
		return (a / ALIGN_BYTES) % STORE_DEPTH;
	endfunction

	function automatic int unsigned size_class(int unsigned s);
		int unsigned k;
		longint unsigned lim;
		k = 0;
		lim = 8;
		while (k < SIZE_CLASSES - 1 && longint'(s) > lim) begin
			k++;
			lim = lim << 1;
		end
		return k;
	endfunction

	task automatic unlink(int unsigned a);
		int unsigned e, c;
		e = gi(a);
		if (c_hasprv[e]) begin
			c_nxt[gi(c_prv[e])] = c_nxt[e];
			c_hasnxt[gi(c_prv[e])] = c_hasnxt[e];
		end else begin
			c = size_class(c_size[e]);
			list_head[c] = c_nxt[e];
			list_ok[c] = c_hasnxt[e];
		end
		if (c_hasnxt[e]) begin
			c_prv[gi(c_nxt[e])] = c_prv[e];
			c_hasprv[gi(c_nxt[e])] = c_hasprv[e];
		end
		c_free[e] = 0;
		free_cell_total--;
	endtask

	task automatic retire(int unsigned a);
		int unsigned e, succ;
		unlink(a);
		e = gi(a);
		succ = a + HEADER_BYTES + c_size[e];
		if (succ >= heap_size) begin
			if (c_haspm[e])
				top_addr = c_pm[e];
		end else begin
			c_pm[gi(succ)] = c_pm[e];
			c_haspm[gi(succ)] = c_haspm[e];
		end
	endtask

	task automatic push_free(int unsigned a);
		int unsigned e, c, succ;
		e = gi(a);
		c = size_class(c_size[e]);
		succ = a + HEADER_BYTES + c_size[e];
		c_hasprv[e] = 0;
		c_prv[e] = 0;
		c_nxt[e] = list_head[c];
		c_hasnxt[e] = list_ok[c];
		if (list_ok[c]) begin
			c_prv[gi(list_head[c])] = a;
			c_hasprv[gi(list_head[c])] = 1;
		end
		list_head[c] = a;
		list_ok[c] = 1;
		c_valid[e] = 1;
		c_free[e] = 1;
		free_cell_total++;
		if (succ >= heap_size) begin
			top_addr = a;
		end else begin
			c_pm[gi(succ)] = a;
			c_haspm[gi(succ)] = 1;
		end
	endtask

	task automatic format_heap();
		for (int i = 0; i < STORE_DEPTH; i++) begin
			c_valid[i] = 0; c_free[i] = 0; c_haspm[i] = 0; c_hasprv[i] = 0;
			c_hasnxt[i] = 0; c_size[i] = 0; c_pm[i] = 0; c_prv[i] = 0; c_nxt[i] = 0;
		end
		for (int i = 0; i < SIZE_CLASSES; i++) begin
			list_head[i] = 0;
			list_ok[i] = 0;
		end
		c_valid[0] = 1;
		c_free[0] = 1;
		c_size[0] = heap_size - HEADER_BYTES;
		list_ok[size_class(c_size[0])] = 1;
		top_addr = 0;
		free_byte_total = c_size[0];
		free_cell_total = 1;
		used_cell_total = 0;
	endtask

	function automatic bit search_class(int unsigned c, int unsigned n, output int unsigned hit);
		int unsigned a, steps;
		bit ok;
		a = list_head[c];
		ok = list_ok[c];
		steps = 0;
		hit = 0;
		while (ok && steps < STORE_DEPTH) begin
			if (c_size[gi(a)] >= n) begin
				hit = a;
				return 1;
			end
			ok = c_hasnxt[gi(a)];
			a = c_nxt[gi(a)];
			steps++;
		end
		return 0;
	endfunction

	task automatic grant(int unsigned req, output status_t st, output int unsigned addr,
			output int unsigned bytes);
		int unsigned n, c, b, e, t;
		bit hit;
		n = req;
		hit = 0;
		b = 0;
		addr = 0;
		bytes = 0;
		if (n == 0) begin
			st = STAT_ZERO;
			return;
		end
		if (n % ALIGN_BYTES)
			n = n - n % ALIGN_BYTES + ALIGN_BYTES;
		c = size_class(n);
		for (int unsigned k = c + 1; k < SIZE_CLASSES && !hit; k++)
			hit = search_class(k, n, b);
		if (!hit)
			hit = search_class(c, n, b);
		if (!hit) begin
			st = STAT_NOSPACE;
			return;
		end
		e = gi(b);
		if (c_size[e] - n <= HEADER_BYTES) begin
			unlink(b);
			free_byte_total -= c_size[e];
		end else begin
			t = b + HEADER_BYTES + n;
			if (t + 1 < heap_size) begin
				c_size[gi(t)] = c_size[e] - n - HEADER_BYTES;
				c_pm[gi(t)] = b;
				c_haspm[gi(t)] = 1;
				push_free(t);
			end
			unlink(b);
			c_size[e] = n;
			free_byte_total -= n + HEADER_BYTES;
		end
		used_cell_total++;
		addr = b + HEADER_BYTES;
		bytes = c_size[e];
		st = STAT_OK;
	endtask

	function automatic status_t find_cell(int unsigned user, output int unsigned a);
		a = 0;
		if (user < HEADER_BYTES)
			return STAT_BADHDR;
		a = user - HEADER_BYTES;
		if (a % ALIGN_BYTES || a + HEADER_BYTES > heap_size || !c_valid[gi(a)])
			return STAT_BADHDR;
		if (c_free[gi(a)])
			return STAT_NOTALLOC;
		return STAT_OK;
	endfunction

	task automatic release_cell(int unsigned a);
		int unsigned e, nx, pa, ph, nh;
		bit pf, nf;
		e = gi(a);
		nx = a + HEADER_BYTES + c_size[e];
		nh = gi(nx);
		pa = c_pm[e];
		ph = gi(pa);
		pf = c_haspm[e] && c_free[ph];
		nf = (nx + 1 < heap_size) && c_free[nh];
		if (pf && nf) begin
			retire(pa);
			retire(nx);
			free_byte_total += c_size[e] + 2 * HEADER_BYTES;
			c_size[ph] += c_size[e] + c_size[nh] + 2 * HEADER_BYTES;
			push_free(pa);
			c_valid[e] = 0;
			c_valid[nh] = 0;
		end else if (pf) begin
			retire(pa);
			free_byte_total += c_size[e] + HEADER_BYTES;
			c_size[ph] += c_size[e] + HEADER_BYTES;
			push_free(pa);
			c_valid[e] = 0;
		end else if (nf) begin
			retire(nx);
			free_byte_total += c_size[e] + HEADER_BYTES;
			c_size[e] += c_size[nh] + HEADER_BYTES;
			push_free(a);
			c_valid[nh] = 0;
		end else begin
			free_byte_total += c_size[e];
			push_free(a);
		end
	endtask

	task automatic predict(op_t op, int unsigned req, int unsigned user);
		res_t r;
		status_t st;
		int unsigned addr, bytes, h;
		addr = 0;
		bytes = 0;
		st = STAT_OK;
		case (op)
			OP_ALLOC: grant(req, st, addr, bytes);
			OP_FREE: begin
				st = find_cell(user, h);
				if (st == STAT_OK) begin
					bytes = c_size[gi(h)];
					release_cell(h);
					used_cell_total--;
				end
			end
			OP_QUERY: begin
				st = find_cell(user, h);
				if (st == STAT_OK)
					bytes = c_size[gi(h)];
			end
			default: ;
		endcase
		r.status = st;
		r.data_address = addr[15:0];
		r.cell_bytes = bytes[15:0];
		r.free_cell_count = free_cell_total[11:0];
		r.used_cell_count = used_cell_total[11:0];
		r.free_byte_count = free_byte_total[16:0];
		expected_responses.push_back(r);
	endtask

	task automatic report(string field, longint unsigned want, longint unsigned got);
		$display("%0t mismatch %s: expected %0d, got %0d", $realtime, field, want, got);
		fail_count++;
	endtask

	task automatic compare(res_t got);
		res_t w;
		if (expected_responses.size() == 0) begin
			$display("%0t unexpected response transaction", $realtime);
			fail_count++;
			return;
		end
		w = expected_responses.pop_front();
		if (got.status != w.status) report("status", w.status, got.status);
		if (got.data_address != w.data_address)
			report("data_address", w.data_address, got.data_address);
		if (got.cell_bytes != w.cell_bytes) report("cell_bytes", w.cell_bytes, got.cell_bytes);
		if (got.free_cell_count != w.free_cell_count)
			report("free_cell_count", w.free_cell_count, got.free_cell_count);
		if (got.used_cell_count != w.used_cell_count)
			report("used_cell_count", w.used_cell_count, got.used_cell_count);
		if (got.free_byte_count != w.free_byte_count)
			report("free_byte_count", w.free_byte_count, got.free_byte_count);
	endtask

	initial fail_count = 0;

	assign pending_count = expected_responses.size();

	always @(posedge clk or negedge arst_n) begin
		int unsigned v;
		res_t got;
		if (!arst_n) begin
			heap_size = HEAP_BYTES;
			format_heap();
			expected_responses.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.data_address = m_axis_tdata[15:0];
				got.cell_bytes = m_axis_tdata[31:16];
				got.free_cell_count = m_axis_tdata[43:32];
				got.used_cell_count = m_axis_tdata[55:44];
				got.free_byte_count = m_axis_tdata[72:56];
				compare(got);
			end
			if (cfg_we) begin
				v = cfg_data;
				if (v < MIN_HEAP) v = MIN_HEAP;
				if (v > HEAP_BYTES) v = HEAP_BYTES;
				heap_size = v - v % ALIGN_BYTES;
				format_heap();
			end
			if (s_axis_tvalid && s_axis_tready)
				predict(op_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]);
		end
	end

endmodule

@@ verif/tb_segregated_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_segregated_free_list_allocator
// Drives allocate, free and size-query transactions into the allocator over
// several heap sizes and back-pressure mixes; the checker predicts and
// compares every response, this module only produces stimulus and the verdict.
// ----------------------------------------------------------------------------
module tb_segregated_free_list_allocator;
	import sfla_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [16:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	int          fail_count;
	int          pending_count;

	int          idle_pct;
	int          stall_pct;
	int          sent_total;
	int          grants_ok;
	int          frees_ok;
	int          heap_settings;
	op_t         ops_in_flight[$];
	logic [15:0] live_cells[$];

	segregated_free_list_allocator u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	sfla_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30ms;
		$display("timeout");
		$display("== FAIL ==");
		$finish;
	end

	always @(negedge clk)
		m_axis_tready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		op_t o;
		if (arst_n && m_axis_tvalid && m_axis_tready && ops_in_flight.size() != 0) begin
			o = ops_in_flight.pop_front();
			if (m_axis_tuser == STAT_OK && o == OP_ALLOC) begin
				live_cells.push_back(m_axis_tdata[15:0]);
				grants_ok++;
			end
			if (m_axis_tuser == STAT_OK && o == OP_FREE)
				frees_ok++;
		end
		if (s_axis_tvalid && s_axis_tready)
			ops_in_flight.push_back(op_t'(s_axis_tuser));
	end

	task automatic send(op_t op, logic [15:0] req, logic [15:0] addr);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tuser = op;
		s_axis_tdata = {addr, req};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 0;
		sent_total++;
	endtask

	task automatic drain();
		while (pending_count != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic set_heap(logic [16:0] v);
		drain();
		cfg_we = 1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 0;
		live_cells.delete();
		heap_settings++;
	endtask

	task automatic free_live(op_t op);
		int k;
		logic [15:0] a;
		k = $urandom_range(live_cells.size() - 1);
		a = live_cells[k];
		if (op == OP_FREE)
			live_cells.delete(k);
		send(op, 16'($urandom), a);
	endtask

	task automatic random_items(int count, int max_req);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (i == count / 2)
				drain();
			if (r < 45 || (r < 85 && live_cells.size() == 0)) begin
				if ($urandom_range(19) == 0)
					send(OP_ALLOC, 16'($urandom), 16'($urandom));
				else
					send(OP_ALLOC, 16'($urandom_range(max_req)), 16'($urandom));
			end else if (r < 77) begin
				free_live(OP_FREE);
			end else if (r < 85) begin
				free_live(OP_QUERY);
			end else if (r < 90) begin
				send(op_t'($urandom_range(1, 2)), 16'($urandom), 16'($urandom));
			end else if (r < 95) begin
				send(op_t'($urandom_range(1, 2)), 16'($urandom), 16'($urandom_range(0, 600)));
			end else begin
				send(OP_NONE, 16'($urandom), 16'($urandom));
			end
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = OP_ALLOC;
		m_axis_tready = 1;
		idle_pct = 0;
		stall_pct = 0;
		sent_total = 0;
		grants_ok = 0;
		frees_ok = 0;
		heap_settings = 1;
		repeat (10) @(negedge clk);
		arst_n = 1;

		send(OP_ALLOC, 16'd0, 16'd0);
		send(OP_ALLOC, 16'hFFFF, 16'hFFFF);
		send(OP_ALLOC, 16'd65512, 16'd0);
		send(OP_QUERY, 16'd0, 16'd24);
		send(OP_FREE, 16'd0, 16'd24);
		send(OP_FREE, 16'd0, 16'd24);
		send(OP_QUERY, 16'd0, 16'd0);
		send(OP_FREE, 16'd0, 16'd23);
		send(OP_FREE, 16'd0, 16'd28);
		send(OP_QUERY, 16'd0, 16'hFFF8);
		send(OP_NONE, 16'hFFFF, 16'hFFFF);
		send(OP_ALLOC, 16'd1, 16'd0);
		send(OP_ALLOC, 16'd9, 16'd0);
		send(OP_ALLOC, 16'd100, 16'd0);
		send(OP_ALLOC, 16'd16, 16'd0);
		send(OP_FREE, 16'd0, 16'd56);
		send(OP_FREE, 16'd0, 16'd24);
		send(OP_FREE, 16'd0, 16'd80);
		send(OP_QUERY, 16'd0, 16'd56);
		send(OP_ALLOC, 16'd40000, 16'd0);
		send(OP_ALLOC, 16'd30000, 16'd0);

		set_heap(17'd0);
		send(OP_ALLOC, 16'd8, 16'd0);
		send(OP_ALLOC, 16'd8, 16'd0);
		send(OP_FREE, 16'd0, 16'd24);
		send(OP_FREE, 16'd0, 16'd64);

		set_heap(17'd65536);
		random_items(250, 512);
		set_heap(17'd1003);
		idle_pct = 56;
		random_items(250, 160);
		set_heap(17'h1FFFF);
		idle_pct = 0;
		stall_pct = 56;
		random_items(250, 2048);
		set_heap(17'd4096);
		idle_pct = 26;
		stall_pct = 26;
		random_items(250, 400);
		set_heap(17'd64);
		idle_pct = 0;
		stall_pct = 0;
		random_items(60, 48);

		drain();
		$display("%0d transactions over %0d heap settings; %0d grants, %0d frees succeeded",
			sent_total, heap_settings, grants_ok, frees_ok);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/sfla_pkg.sv
rtl/sfla_hdr_ram.sv
rtl/sfla_engine.sv
rtl/segregated_free_list_allocator.sv
verif/sfla_checker.sv
verif/tb_segregated_free_list_allocator.sv
